// ===== sv/qslerp_pkg.sv =====
// Package for the quaternion slerp block: payload structs, stage map,
// fixed-point constants and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package qslerp_pkg;

  // Input transfer: two quaternions (Q2.14) and the blend factor (Q1.15)
  typedef struct packed {
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] a_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic signed [15:0] b_w;
    logic [15:0]        alpha;
  } in_t;

  // Output transfer: blended quaternion, Q2.14, saturated
  typedef struct packed {
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
    logic signed [15:0] q_w;
  } out_t;

  // Per-item data that rides along the pipe up to the blend products stage
  typedef struct packed {
    logic [3:0][15:0] a;      // first quaternion
    logic [3:0][16:0] b;      // second quaternion, sign-fixed
    logic [15:0]      alpha;
    logic             lin;    // cosine above threshold: linear weights
    logic [28:0]      cc;     // clamped cosine, Q28
    logic [28:0]      s;      // sine, Q28
  } side_t;

  // Register map
  localparam int             PADDR_W            = 3;
  localparam int             REG_NEAR_THRESHOLD = 0;
  localparam logic [14:0]    THR_RESET          = 15'd16382;

  // Iteration counts
  localparam int CORDIC_STEPS = 16;   // 8..24
  localparam int SQ_STEPS     = 29;   // root bits of a 57-bit radicand
  localparam int DIV_STEPS    = 33;   // quotient bits below the overflow check

  // Stage map (index = register stage number)
  localparam int P_MUL    = 1;
  localparam int P_DOT    = 2;
  localparam int P_SQ     = 3;
  localparam int P_SQ_END = P_SQ + SQ_STEPS;
  localparam int P_AT0    = P_SQ_END + 1;
  localparam int P_AT_END = P_SQ_END + CORDIC_STEPS;
  localparam int P_ANG    = P_AT_END + 1;
  localparam int P_REF    = P_ANG + 1;
  localparam int P_SN_END = P_REF + CORDIC_STEPS;
  localparam int P_PRE    = P_SN_END + 1;
  localparam int P_DV_END = P_PRE + DIV_STEPS;
  localparam int P_K      = P_DV_END + 1;
  localparam int P_OUT    = P_K + 1;

  // Fixed-point constants
  localparam logic [28:0]        ONE_Q28     = 29'h1000_0000;
  localparam logic [57:0]        TWO_P56     = 58'h100_0000_0000_0000;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
  localparam logic [32:0]        WEIGHT_MAX  = 33'h1_0000_0000;

  // atan(2^-i) in Q30, truncated
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd843314856;
      5'd1:    v = 30'd497837829;
      5'd2:    v = 30'd263043836;
      5'd3:    v = 30'd133525158;
      5'd4:    v = 30'd67021686;
      5'd5:    v = 30'd33543515;
      5'd6:    v = 30'd16775850;
      5'd7:    v = 30'd8388437;
      5'd8:    v = 30'd4194282;
      5'd9:    v = 30'd2097149;
      5'd10:   v = 30'd1048575;
      5'd11:   v = 30'd524287;
      5'd12:   v = 30'd262143;
      5'd13:   v = 30'd131071;
      5'd14:   v = 30'd65535;
      5'd15:   v = 30'd32767;
      5'd16:   v = 30'd16383;
      5'd17:   v = 30'd8191;
      5'd18:   v = 30'd4095;
      5'd19:   v = 30'd2047;
      5'd20:   v = 30'd1023;
      5'd21:   v = 30'd511;
      5'd22:   v = 30'd255;
      5'd23:   v = 30'd127;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/quaternion_slerp.sv =====
// Quaternion slerp top level: dot product, square root, CORDIC atan2,
// CORDIC sines, long division and final blend. Uses qslerp_pkg.
`default_nettype none

// Throughput: one item per cycle; the whole pipe holds only while the
// output register is full and not taken.
// Stage depth is set by one bit of square root or division (a compare and
// subtract of up to 62 bits) or one CORDIC step.
// Reset clears all valid bits and loads near_threshold with 16382.
module quaternion_slerp (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  qslerp_pkg::in_t               in_data_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output qslerp_pkg::out_t              out_data_o,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire [qslerp_pkg::PADDR_W-1:0] paddr,
  input  wire [31:0]                    pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int CS = qslerp_pkg::CORDIC_STEPS;
  localparam int SQ = qslerp_pkg::SQ_STEPS;
  localparam int DV = qslerp_pkg::DIV_STEPS;
  localparam int NS = qslerp_pkg::P_OUT;
  localparam int NK = qslerp_pkg::P_K;

  // ---------------- configuration ----------------
  logic [14:0] thr_q;
  logic        reg_sel;

  assign reg_sel = (32'(paddr[qslerp_pkg::PADDR_W-1]) == qslerp_pkg::REG_NEAR_THRESHOLD);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {17'd0, thr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= qslerp_pkg::THR_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      thr_q <= pwdata[14:0];
    end
  end

  // ---------------- pipeline control ----------------
  logic adv;
  logic vld_q [1:NS];

  assign adv         = !vld_q[NS] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= NS; k++) vld_q[k] <= 1'b0;
    end else if (adv) begin
      vld_q[1] <= in_valid_i;
      for (int k = 2; k <= NS; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // ---------------- input unpack ----------------
  logic signed [15:0] in_a [4];
  logic signed [15:0] in_b [4];

  always_comb begin
    in_a[0] = in_data_i.a_x;
    in_a[1] = in_data_i.a_y;
    in_a[2] = in_data_i.a_z;
    in_a[3] = in_data_i.a_w;
    in_b[0] = in_data_i.b_x;
    in_b[1] = in_data_i.b_y;
    in_b[2] = in_data_i.b_z;
    in_b[3] = in_data_i.b_w;
  end

  // ---------------- stage 1: component products ----------------
  logic signed [31:0] prod_q [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) prod_q[i] <= in_a[i] * in_b[i];
    end
  end

  // ---------------- stage 2: dot product, sign fix, threshold ----------------
  logic signed [33:0] dot;
  logic               dot_neg;
  logic [33:0]        dot_abs;
  logic               dot_lin;
  logic [28:0]        dot_cc;

  always_comb begin
    dot = 34'(prod_q[0]) + 34'(prod_q[1]) + 34'(prod_q[2]) + 34'(prod_q[3]);
    dot_neg = dot[33];
    dot_abs = dot_neg ? 34'(-dot) : 34'(dot);
    dot_lin = dot_abs > 34'({thr_q, 14'd0});
    dot_cc  = (dot_abs > 34'(qslerp_pkg::ONE_Q28)) ? qslerp_pkg::ONE_Q28 : dot_abs[28:0];
  end

  // ---------------- side data chain ----------------
  qslerp_pkg::side_t side_q [1:NK];
  qslerp_pkg::side_t side_d [1:NK];
  logic [28:0]       sq_root_q [SQ];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      side_d[1].a[i] = in_a[i];
      side_d[1].b[i] = 17'(in_b[i]);
    end
    side_d[1].alpha = in_data_i.alpha;
    side_d[1].lin   = 1'b0;
    side_d[1].cc    = '0;
    side_d[1].s     = '0;
    for (int k = 2; k <= NK; k++) side_d[k] = side_q[k-1];
    // sign fix of b and the branch decision
    for (int i = 0; i < 4; i++) begin
      side_d[qslerp_pkg::P_DOT].b[i] = dot_neg ? 17'(-$signed(side_q[qslerp_pkg::P_MUL].b[i]))
                                               : side_q[qslerp_pkg::P_MUL].b[i];
    end
    side_d[qslerp_pkg::P_DOT].lin = dot_lin;
    side_d[qslerp_pkg::P_DOT].cc  = dot_cc;
    // sine joins once the root is done
    side_d[qslerp_pkg::P_AT0].s = sq_root_q[SQ-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 1; k <= NK; k++) side_q[k] <= side_d[k];
    end
  end

  // ---------------- stage 3: radicand 1 - cos^2 ----------------
  logic [57:0] cc_sq;
  logic [56:0] s2_q;

  assign cc_sq = side_q[qslerp_pkg::P_DOT].cc * side_q[qslerp_pkg::P_DOT].cc;

  always_ff @(posedge clk_i) begin
    if (adv) s2_q <= 57'(qslerp_pkg::TWO_P56 - cc_sq);
  end

  // ---------------- square root, one root bit per stage ----------------
  logic [56:0] sq_rem_q [SQ];

  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam int B = SQ - 1 - j;
    logic [56:0] rem_in;
    logic [28:0] root_in;
    logic [58:0] trial;
    logic        take;

    if (j == 0) begin : g_first
      assign rem_in  = s2_q;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = sq_rem_q[j-1];
      assign root_in = sq_root_q[j-1];
    end

    assign trial = (59'(root_in) << (B + 1)) + (59'(1) << (2 * B));
    assign take  = 59'(rem_in) >= trial;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem_q[j]  <= take ? 57'(59'(rem_in) - trial) : rem_in;
        sq_root_q[j] <= take ? (root_in | (29'(1) << B)) : root_in;
      end
    end
  end

  // ---------------- atan2 by vectoring CORDIC ----------------
  logic signed [33:0] at_x_q [CS];
  logic signed [33:0] at_y_q [CS];
  logic signed [33:0] at_z_q [CS];

  for (genvar i = 0; i < CS; i++) begin : g_atan
    logic signed [33:0] x_in, y_in, z_in, ang;

    if (i == 0) begin : g_first
      assign x_in = $signed({5'd0, side_q[qslerp_pkg::P_SQ_END].cc});
      assign y_in = $signed({5'd0, sq_root_q[SQ-1]});
      assign z_in = '0;
    end else begin : g_next
      assign x_in = at_x_q[i-1];
      assign y_in = at_y_q[i-1];
      assign z_in = at_z_q[i-1];
    end

    assign ang = $signed({4'd0, qslerp_pkg::atan_q30(5'(i))});

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!y_in[33]) begin
          at_x_q[i] <= x_in + (y_in >>> i);
          at_y_q[i] <= y_in - (x_in >>> i);
          at_z_q[i] <= z_in + ang;
        end else begin
          at_x_q[i] <= x_in - (y_in >>> i);
          at_y_q[i] <= y_in + (x_in >>> i);
          at_z_q[i] <= z_in - ang;
        end
      end
    end
  end

  // ---------------- scaled angles (1-alpha)*theta and alpha*theta ----------------
  logic signed [16:0] ang_w [2];
  logic signed [50:0] ang_p [2];
  logic signed [33:0] ang_q [2];

  assign ang_w[1] = $signed({1'b0, side_q[qslerp_pkg::P_AT_END].alpha});
  assign ang_w[0] = $signed(17'h08000) - ang_w[1];

  always_comb begin
    for (int l = 0; l < 2; l++) ang_p[l] = at_z_q[CS-1] * ang_w[l];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) ang_q[l] <= 34'(ang_p[l] >>> 15);
    end
  end

  // ---------------- fold angle into [-pi/2, pi/2] ----------------
  logic signed [33:0] ref_q [2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        if (ang_q[l] > qslerp_pkg::HALF_PI_Q30) begin
          ref_q[l] <= qslerp_pkg::PI_Q30 - ang_q[l];
        end else if (ang_q[l] < -qslerp_pkg::HALF_PI_Q30) begin
          ref_q[l] <= -qslerp_pkg::PI_Q30 - ang_q[l];
        end else begin
          ref_q[l] <= ang_q[l];
        end
      end
    end
  end

  // ---------------- sines by rotation CORDIC, two lanes ----------------
  logic signed [33:0] sn_x_q [2][CS];
  logic signed [33:0] sn_y_q [2][CS];
  logic signed [33:0] sn_z_q [2][CS];

  for (genvar l = 0; l < 2; l++) begin : g_sin_lane
    for (genvar i = 0; i < CS; i++) begin : g_sin
      logic signed [33:0] x_in, y_in, z_in, ang;

      if (i == 0) begin : g_first
        assign x_in = qslerp_pkg::CORDIC_K;
        assign y_in = '0;
        assign z_in = ref_q[l];
      end else begin : g_next
        assign x_in = sn_x_q[l][i-1];
        assign y_in = sn_y_q[l][i-1];
        assign z_in = sn_z_q[l][i-1];
      end

      assign ang = $signed({4'd0, qslerp_pkg::atan_q30(5'(i))});

      always_ff @(posedge clk_i) begin
        if (adv) begin
          if (!z_in[33]) begin
            sn_x_q[l][i] <= x_in - (y_in >>> i);
            sn_y_q[l][i] <= y_in + (x_in >>> i);
            sn_z_q[l][i] <= z_in - ang;
          end else begin
            sn_x_q[l][i] <= x_in + (y_in >>> i);
            sn_y_q[l][i] <= y_in - (x_in >>> i);
            sn_z_q[l][i] <= z_in + ang;
          end
        end
      end
    end
  end

  // ---------------- division setup: sin*2^28 / s ----------------
  logic [61:0] pre_r_q   [2];
  logic        pre_neg_q [2];
  logic        pre_ovf_q [2];
  logic [33:0] pre_mag   [2];
  logic [61:0] pre_num   [2];
  logic [61:0] pre_lim;

  assign pre_lim = {side_q[qslerp_pkg::P_SN_END].s, 33'd0};

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      pre_mag[l] = sn_y_q[l][CS-1][33] ? 34'(-sn_y_q[l][CS-1]) : 34'(sn_y_q[l][CS-1]);
      pre_num[l] = {pre_mag[l], 28'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        pre_r_q[l]   <= pre_num[l];
        pre_neg_q[l] <= sn_y_q[l][CS-1][33];
        pre_ovf_q[l] <= pre_num[l] >= pre_lim;
      end
    end
  end

  // ---------------- long division, one quotient bit per stage ----------------
  logic [61:0] dv_r_q   [2][DV];
  logic [32:0] dv_q_q   [2][DV];
  logic        dv_neg_q [2][DV];
  logic        dv_ovf_q [2][DV];

  for (genvar l = 0; l < 2; l++) begin : g_div_lane
    for (genvar j = 0; j < DV; j++) begin : g_div
      localparam int B = DV - 1 - j;
      logic [61:0] r_in;
      logic [32:0] q_in;
      logic        neg_in, ovf_in, take;
      logic [61:0] trial;

      if (j == 0) begin : g_first
        assign r_in   = pre_r_q[l];
        assign q_in   = '0;
        assign neg_in = pre_neg_q[l];
        assign ovf_in = pre_ovf_q[l];
      end else begin : g_next
        assign r_in   = dv_r_q[l][j-1];
        assign q_in   = dv_q_q[l][j-1];
        assign neg_in = dv_neg_q[l][j-1];
        assign ovf_in = dv_ovf_q[l][j-1];
      end

      assign trial = 62'(side_q[qslerp_pkg::P_PRE + j].s) << B;
      assign take  = r_in >= trial;

      always_ff @(posedge clk_i) begin
        if (adv) begin
          dv_r_q[l][j]   <= take ? (r_in - trial) : r_in;
          dv_q_q[l][j]   <= take ? (q_in | (33'(1) << B)) : q_in;
          dv_neg_q[l][j] <= neg_in;
          dv_ovf_q[l][j] <= ovf_in;
        end
      end
    end
  end

  // ---------------- weight select and blend products ----------------
  qslerp_pkg::side_t  kside;
  logic               k_lin;
  logic [32:0]        k_mag [2];
  logic signed [33:0] k_sin [2];
  logic signed [16:0] k_w   [2];
  logic signed [33:0] k_val [2];
  logic signed [50:0] pa_q  [4];
  logic signed [50:0] pb_q  [4];

  assign kside  = side_q[qslerp_pkg::P_DV_END];
  assign k_lin  = kside.lin || (kside.s == '0);
  assign k_w[1] = $signed({1'b0, kside.alpha});
  assign k_w[0] = $signed(17'h08000) - k_w[1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (dv_ovf_q[l][DV-1] || (dv_q_q[l][DV-1] > qslerp_pkg::WEIGHT_MAX)) begin
        k_mag[l] = qslerp_pkg::WEIGHT_MAX;
      end else begin
        k_mag[l] = dv_q_q[l][DV-1];
      end
      k_sin[l] = dv_neg_q[l][DV-1] ? -$signed({1'b0, k_mag[l]}) : $signed({1'b0, k_mag[l]});
      k_val[l] = k_lin ? (34'(k_w[l]) <<< 15) : k_sin[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        pa_q[i] <= $signed(kside.a[i]) * k_val[0];
        pb_q[i] <= $signed(kside.b[i]) * k_val[1];
      end
    end
  end

  // ---------------- sum, round, saturate into the output register ----------------
  logic signed [51:0] acc [4];
  logic signed [21:0] rnd [4];
  logic signed [15:0] sat [4];
  qslerp_pkg::out_t   out_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc[i] = 52'(pa_q[i]) + 52'(pb_q[i]) + 52'sd536870912;
      rnd[i] = 22'(acc[i] >>> 30);
      if (rnd[i] > 22'sd32767) begin
        sat[i] = 16'sh7fff;
      end else if (rnd[i] < -22'sd32768) begin
        sat[i] = 16'sh8000;
      end else begin
        sat[i] = 16'(rnd[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.q_x <= sat[0];
      out_q.q_y <= sat[1];
      out_q.q_z <= sat[2];
      out_q.q_w <= sat[3];
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire
